// ===== rtl/core/mrec_pkg.sv =====
// Shared types, constants and helpers for the region execute-permission checker.
package mrec_pkg;

  localparam int unsigned REGIONS = 8;
  localparam int unsigned RIDX_W  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int unsigned CMP_W   = (RIDX_W > 3) ? RIDX_W : 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [1:0] CFG_PROTECT    = 2'd0;
  localparam logic [1:0] CFG_BACKGROUND = 2'd1;
  localparam logic [1:0] CFG_LIMIT_MODE = 2'd2;

  localparam logic [2:0] AP_NO_ACCESS = 3'd0;
  localparam logic [2:0] AP_RESERVED  = 3'd4;
  localparam logic [4:0] SIZE_MIN     = 5'd4;
  localparam logic [4:0] SIZE_SUBREG  = 5'd7;

  localparam logic [31:0] DEF_LOW_END  = 32'h4000_0000;
  localparam logic [31:0] DEF_MID_BASE = 32'h6000_0000;
  localparam logic [31:0] DEF_MID_END  = 32'hA000_0000;

  typedef enum logic [1:0] {
    KIND_BACKGROUND = 2'd0,
    KIND_REGION     = 2'd1,
    KIND_FAULT      = 2'd2
  } kind_t;

  typedef struct packed {
    logic [26:0] base;
    logic [26:0] limit;
    logic [4:0]  size_code;
    logic        region_on;
    logic [7:0]  subregion_off;
    logic [2:0]  access_code;
    logic        no_exec;
    logic        no_priv_exec;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic              opcode;
    logic [2:0]        region_index;
    logic [31:0]       addr;
    entry_t            entry;
    logic              found;
    logic              multi;
    logic [RIDX_W-1:0] hit;
    logic              allow;
  } beat_t;

  function automatic logic default_exec(input logic [31:0] a);
    return (a < DEF_LOW_END) || ((a >= DEF_MID_BASE) && (a < DEF_MID_END));
  endfunction

endpackage

// ===== rtl/core/mrec_cell.sv =====
// One region cell: holds one table entry and checks the beat passing through it.
module mrec_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        limit_mode,
  input  logic [mrec_pkg::RIDX_W-1:0] cell_id,
  input  mrec_pkg::beat_t             beat_in,
  output mrec_pkg::beat_t             beat_out
);
  import mrec_pkg::*;

  entry_t      ent;
  beat_t       nxt;
  logic [32:0] span;
  logic [31:0] low_mask;
  logic [31:0] rbase;
  logic [31:0] off;
  logic [4:0]  shamt;
  logic [2:0]  sub;
  logic        pow_hit;
  logic        lim_hit;
  logic        allow_pow;
  logic        allow_lim;
  logic        wr_hit;

  always_comb begin
    span      = 33'd1 << (6'(ent.size_code) + 6'd1);
    low_mask  = 32'(span - 33'd1);
    rbase     = {ent.base, 5'b0} & ~low_mask;
    off       = beat_in.addr & low_mask;
    shamt     = ent.size_code - 5'd2;
    sub       = 3'(off >> shamt);
    pow_hit   = ent.region_on && (ent.size_code >= SIZE_MIN)
                && ((beat_in.addr & ~low_mask) == rbase)
                && !((ent.size_code >= SIZE_SUBREG) && ent.subregion_off[sub]);
    lim_hit   = ent.region_on && (beat_in.addr[31:5] >= ent.base)
                && (beat_in.addr[31:5] <= ent.limit);
    allow_pow = !ent.no_exec && (ent.access_code != AP_NO_ACCESS)
                && (ent.access_code != AP_RESERVED);
    allow_lim = !ent.no_exec && !ent.no_priv_exec;
    wr_hit    = beat_in.valid && (beat_in.opcode == OP_WRITE)
                && (CMP_W'(beat_in.region_index) == CMP_W'(cell_id));
  end

  always_comb begin
    nxt = beat_in;
    if (beat_in.valid && (beat_in.opcode == OP_CHECK)) begin
      if (limit_mode) begin
        if (lim_hit) begin
          if (beat_in.found) begin
            nxt.multi = 1'b1;
          end else begin
            nxt.found = 1'b1;
            nxt.hit   = cell_id;
            nxt.allow = allow_lim;
          end
        end
      end else if (pow_hit) begin
        // higher cells come later, so the last hit wins
        nxt.found = 1'b1;
        nxt.hit   = cell_id;
        nxt.allow = allow_pow;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
      ent.region_on  <= 1'b0;
    end else if (adv) begin
      beat_out <= nxt;
      if (wr_hit) begin
        ent <= beat_in.entry;
      end
    end
  end

endmodule

// ===== rtl/core/mpu_region_exec_check.sv =====
// Top level: region table as a chain of cells, config registers and result register.
// Each beat walks a row of REGIONS cells, one cell per cycle while the row
// advances, and each cell holds one region entry. Write beats update their cell
// on the way; check beats gather the match as they pass. Throughput is one beat
// per cycle while the row advances; a beat passes the REGIONS cell registers,
// then the result register, and the whole row holds while a result waits on m_tready.
// Write beats give no result. Configuration is taken on any cycle with cfg_valid.
module mpu_region_exec_check (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // region_index[2:0], check_address[34:3], region_base[61:35],
  // region_limit[88:62], size_code[93:89], region_on[94],
  // subregion_off[102:95], access_code[105:103], no_exec[106],
  // no_priv_exec[107], zero[111:108]
  input  logic [111:0] s_tdata,
  // opcode[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // executable[0], decider_kind[2:1], decider_index[5:3], zero[7:6]
  output logic [7:0]   m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic         cfg_data
);
  import mrec_pkg::*;

  beat_t chain [0:REGIONS];
  logic  adv;
  logic  protection_enable;
  logic  background_enable;
  logic  limit_mode;
  logic  res_exec;
  kind_t res_kind;
  logic [2:0] res_index;
  beat_t last;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv && !rst;
  assign cfg_ready = !rst;

  always_comb begin
    chain[0].valid              = s_tvalid;
    chain[0].opcode             = s_tuser;
    chain[0].region_index       = s_tdata[2:0];
    chain[0].addr               = s_tdata[34:3];
    chain[0].entry.base         = s_tdata[61:35];
    chain[0].entry.limit        = s_tdata[88:62];
    chain[0].entry.size_code    = s_tdata[93:89];
    chain[0].entry.region_on    = s_tdata[94];
    chain[0].entry.subregion_off = s_tdata[102:95];
    chain[0].entry.access_code  = s_tdata[105:103];
    chain[0].entry.no_exec      = s_tdata[106];
    chain[0].entry.no_priv_exec = s_tdata[107];
    chain[0].found              = 1'b0;
    chain[0].multi              = 1'b0;
    chain[0].hit                = '0;
    chain[0].allow              = 1'b0;
  end

  for (genvar i = 0; i < REGIONS; i++) begin : g_cell
    mrec_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .limit_mode (limit_mode),
      .cell_id    (RIDX_W'(i)),
      .beat_in    (chain[i]),
      .beat_out   (chain[i+1])
    );
  end

  assign last = chain[REGIONS];

  always_comb begin
    res_exec  = 1'b0;
    res_kind  = KIND_BACKGROUND;
    res_index = 3'd0;
    if (!protection_enable) begin
      res_exec = default_exec(last.addr);
    end else if (last.multi) begin
      res_kind = KIND_FAULT;
    end else if (last.found) begin
      res_exec  = last.allow;
      res_kind  = KIND_REGION;
      res_index = 3'(last.hit);
    end else begin
      res_exec = background_enable && default_exec(last.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= last.valid && (last.opcode == OP_CHECK);
      m_tdata  <= {2'b00, res_index, res_kind, res_exec};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protection_enable <= 1'b0;
      background_enable <= 1'b0;
      limit_mode        <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PROTECT:    protection_enable <= cfg_data;
        CFG_BACKGROUND: background_enable <= cfg_data;
        CFG_LIMIT_MODE: limit_mode        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/mrec_checker.sv =====
// Port-level checks for the region execute-permission checker, bound to the top.
module mrec_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [7:0]   m_tdata
);
  import mrec_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_fault_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:1] == KIND_FAULT) |-> !m_tdata[0] && (m_tdata[5:3] == 3'd0))
    else $error("fault result must deny with index zero");

  a_bg_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:1] == KIND_BACKGROUND) |-> (m_tdata[5:3] == 3'd0))
    else $error("background result must carry index zero");

  a_stall_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind mpu_region_exec_check mrec_checker u_mrec_checker (.*);
